/* src/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// operation codes, status codes and cell control types for the deque
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

   localparam int KIND_WIDTH   = 3;
   localparam int STATUS_WIDTH = 2;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_REAR  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_REAR   = 3'd3,
      KIND_CLEAR      = 3'd4
   } kind_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDERFLOW = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SHIFT_FROM_LEFT,
      CELL_APPEND,
      CELL_SHIFT_FROM_RIGHT,
      CELL_DROP_REAR,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctl_type;

endpackage

`default_nettype wire

/* src/deq_if.sv */
// ----------------------------------------------------------------------------
// deq_if
// valid/ready channels carrying deque operations and deque results
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_req_if #(
   parameter int DATA_WIDTH = 32
);
   import deq_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [KIND_WIDTH-1:0] kind;
   logic [DATA_WIDTH-1:0] data_in;

   modport source (output valid, output kind, output data_in, input ready);
   modport sink   (input valid, input kind, input data_in, output ready);
endinterface

interface deq_rsp_if #(
   parameter int DATA_WIDTH  = 32,
   parameter int COUNT_WIDTH = 5
);
   import deq_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [DATA_WIDTH-1:0]   popped_value;
   logic [STATUS_WIDTH-1:0] status;
   logic [COUNT_WIDTH-1:0]  entry_count;
   logic [DATA_WIDTH-1:0]   front_value;
   logic [DATA_WIDTH-1:0]   rear_value;
   logic                    is_empty;

   modport source (output valid, output popped_value, output status, output entry_count,
                   output front_value, output rear_value, output is_empty, input ready);
   modport sink   (input valid, input popped_value, input status, input entry_count,
                   input front_value, input rear_value, input is_empty, output ready);
endinterface

`default_nettype wire

/* src/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded deque built as a row of shifting cells with a registered result
// ----------------------------------------------------------------------------
// The deque takes one operation per beat (push front, push rear, pop front,
// pop rear, clear) and returns one result beat for each, registered in the cycle
// after acceptance. It sustains one operation per cycle: a new beat is accepted
// whenever the result register is empty or its beat is taken in the same
// cycle. Entries sit in a row of DEPTH cells with the front in the first
// cell; every cell updates in the same cycle, and the rear value comes from
// a one-hot select across the row. Pushes on a full deque are dropped with
// overflow status, pops on an empty deque return zero with underflow status.
`default_nettype none

module double_ended_queue #(
   parameter int DATA_WIDTH  = 32,
   parameter int DEPTH       = 16,
   parameter int COUNT_WIDTH = $clog2(DEPTH + 1)
) (
   input wire logic clock,
   input wire logic reset,
   deq_req_if.sink  req_bus,
   deq_rsp_if.source rsp_bus
);
   import deq_pkg::*;

   logic [DATA_WIDTH-1:0]  cell_entry [DEPTH];
   logic [DEPTH-1:0]       cell_occupied;
   logic [DEPTH-1:0]       cell_is_rear;
   cell_ctl_type           ctl;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [DATA_WIDTH-1:0]  popped_ff;
   logic [DATA_WIDTH-1:0]  popped_in;
   status_type             status_ff;
   status_type             status_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;

   logic                   accept;
   logic                   full;
   logic                   empty;
   logic [DATA_WIDTH-1:0]  front_data;
   logic [DATA_WIDTH-1:0]  rear_data;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign full          = cell_occupied[DEPTH-1];
   assign empty         = !cell_occupied[0];
   assign front_data    = cell_occupied[0] ? cell_entry[0] : '0;

   always_comb begin
      rear_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_is_rear[i]) begin
            rear_data = rear_data | cell_entry[i];
         end
      end
   end

   // the row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_entry;
      logic                  left_occupied;
      logic [DATA_WIDTH-1:0] right_entry;
      logic                  right_occupied;

      if (i == 0) begin : g_first
         assign left_entry    = req_bus.data_in;
         assign left_occupied = 1'b1;
      end else begin : g_inner_left
         assign left_entry    = cell_entry[i-1];
         assign left_occupied = cell_occupied[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry    = '0;
         assign right_occupied = 1'b0;
      end else begin : g_inner_right
         assign right_entry    = cell_entry[i+1];
         assign right_occupied = cell_occupied[i+1];
      end

      deq_cell #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .push_data     (req_bus.data_in),
         .left_entry    (left_entry),
         .left_occupied (left_occupied),
         .right_entry   (right_entry),
         .right_occupied(right_occupied),
         .entry         (cell_entry[i]),
         .occupied      (cell_occupied[i]),
         .is_rear       (cell_is_rear[i])
      );
   end

   // operation decode
   always_comb begin
      ctl.op    = CELL_HOLD;
      status_in = STATUS_OK;
      popped_in = '0;
      count_in  = count_ff;
      if (accept) begin
         unique case (req_bus.kind)
            KIND_PUSH_FRONT: begin
               if (full) begin
                  status_in = STATUS_OVERFLOW;
               end else begin
                  ctl.op   = CELL_SHIFT_FROM_LEFT;
                  count_in = count_ff + COUNT_WIDTH'(1);
               end
            end
            KIND_PUSH_REAR: begin
               if (full) begin
                  status_in = STATUS_OVERFLOW;
               end else begin
                  ctl.op   = CELL_APPEND;
                  count_in = count_ff + COUNT_WIDTH'(1);
               end
            end
            KIND_POP_FRONT: begin
               if (empty) begin
                  status_in = STATUS_UNDERFLOW;
               end else begin
                  ctl.op    = CELL_SHIFT_FROM_RIGHT;
                  popped_in = front_data;
                  count_in  = count_ff - COUNT_WIDTH'(1);
               end
            end
            KIND_POP_REAR: begin
               if (empty) begin
                  status_in = STATUS_UNDERFLOW;
               end else begin
                  ctl.op    = CELL_DROP_REAR;
                  popped_in = rear_data;
                  count_in  = count_ff - COUNT_WIDTH'(1);
               end
            end
            KIND_CLEAR: begin
               ctl.op   = CELL_CLEAR;
               count_in = '0;
            end
            default: begin
               ctl.op = CELL_HOLD;
            end
         endcase
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         popped_ff <= popped_in;
         status_ff <= status_in;
      end
   end

   // front and rear follow the row, which only moves when an operation is accepted and holds while a result beat waits
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.popped_value = popped_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.entry_count  = count_ff;
   assign rsp_bus.front_value  = front_data;
   assign rsp_bus.rear_value   = rear_data;
   assign rsp_bus.is_empty     = empty;

endmodule

`default_nettype wire

/* src/deq_cell.sv */
// ----------------------------------------------------------------------------
// deq_cell
// one slot of the deque row: holds an entry and shifts with its neighbours
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire deq_pkg::cell_ctl_type ctl,
   input  wire logic [DATA_WIDTH-1:0] push_data,
   input  wire logic [DATA_WIDTH-1:0] left_entry,
   input  wire logic                  left_occupied,
   input  wire logic [DATA_WIDTH-1:0] right_entry,
   input  wire logic                  right_occupied,
   output      logic [DATA_WIDTH-1:0] entry,
   output      logic                  occupied,
   output      logic                  is_rear
);
   import deq_pkg::*;

   logic [DATA_WIDTH-1:0] entry_ff;
   logic [DATA_WIDTH-1:0] entry_in;
   logic                  occupied_ff;
   logic                  occupied_in;

   // shift from either side, append at first free slot, drop rear, clear
   always_comb begin
      entry_in    = entry_ff;
      occupied_in = occupied_ff;
      unique case (ctl.op)
         CELL_SHIFT_FROM_LEFT: begin
            entry_in    = left_entry;
            occupied_in = left_occupied;
         end
         CELL_APPEND: begin
            if (!occupied_ff && left_occupied) begin
               entry_in    = push_data;
               occupied_in = 1'b1;
            end
         end
         CELL_SHIFT_FROM_RIGHT: begin
            entry_in    = right_entry;
            occupied_in = right_occupied;
         end
         CELL_DROP_REAR: occupied_in = occupied_ff && right_occupied;
         CELL_CLEAR:     occupied_in = 1'b0;
         default: begin
            entry_in    = entry_ff;
            occupied_in = occupied_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff <= 1'b0;
      end else begin
         occupied_ff <= occupied_in;
      end
   end

   assign entry    = entry_ff;
   assign occupied = occupied_ff;
   assign is_rear  = occupied_ff && !right_occupied;

endmodule

`default_nettype wire

/* tb/deq_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deq_checker
// watches both deque channels, predicts each result beat and compares it
// ----------------------------------------------------------------------------
// Every accepted operation beat is run through a ring-store model of the
// deque and its expected result is queued. Every accepted result beat is
// compared field by field with the oldest queued result. The number of
// mismatches and the number of results still owed go back to the top.
// ----------------------------------------------------------------------------

module deq_checker #(
   parameter int DATA_WIDTH  = 32,
   parameter int DEPTH       = 16,
   parameter int COUNT_WIDTH = 5
) (
   input  logic clock,
   input  logic reset,
   deq_req_if   req_mon,
   deq_rsp_if   rsp_mon,
   output int   mismatch_total,
   output int   results_owed
);
   import deq_pkg::*;

   localparam int INDEX_WIDTH = $clog2(DEPTH);

   typedef struct packed {
      logic [DATA_WIDTH-1:0]  popped;
      status_type             status;
      logic [COUNT_WIDTH-1:0] count;
      logic [DATA_WIDTH-1:0]  front;
      logic [DATA_WIDTH-1:0]  rear;
      logic                   empty;
   } deq_result_type;

   logic [DATA_WIDTH-1:0]  ring_words [DEPTH];
   logic [INDEX_WIDTH-1:0] head_slot;
   logic [COUNT_WIDTH-1:0] held_total;
   deq_result_type         owed_results [$];
   int                     error_tally = 0;

   function automatic logic [INDEX_WIDTH-1:0] ring_slot(input int offset);
      return INDEX_WIDTH'((int'(head_slot) + offset) % DEPTH);
   endfunction

   function automatic deq_result_type apply_operation(input logic [KIND_WIDTH-1:0] op,
                                                      input logic [DATA_WIDTH-1:0] value);
      deq_result_type res;
      res        = '0;
      res.status = STATUS_OK;
      case (op)
         KIND_PUSH_FRONT: begin
            if (held_total >= DEPTH) begin
               res.status = STATUS_OVERFLOW;
            end else begin
               head_slot             = ring_slot(DEPTH - 1);
               ring_words[head_slot] = value;
               held_total            = held_total + 1'b1;
            end
         end
         KIND_PUSH_REAR: begin
            if (held_total >= DEPTH) begin
               res.status = STATUS_OVERFLOW;
            end else begin
               ring_words[ring_slot(int'(held_total))] = value;
               held_total = held_total + 1'b1;
            end
         end
         KIND_POP_FRONT: begin
            if (held_total == 0) begin
               res.status = STATUS_UNDERFLOW;
            end else begin
               res.popped = ring_words[head_slot];
               head_slot  = ring_slot(1);
               held_total = held_total - 1'b1;
               if (held_total == 0) head_slot = '0;
            end
         end
         KIND_POP_REAR: begin
            if (held_total == 0) begin
               res.status = STATUS_UNDERFLOW;
            end else begin
               res.popped = ring_words[ring_slot(int'(held_total) + DEPTH - 1)];
               held_total = held_total - 1'b1;
               if (held_total == 0) head_slot = '0;
            end
         end
         KIND_CLEAR: begin
            head_slot  = '0;
            held_total = '0;
         end
         default: begin
         end
      endcase
      res.count = held_total;
      if (held_total == 0) begin
         res.empty = 1'b1;
      end else begin
         res.front = ring_words[head_slot];
         res.rear  = ring_words[ring_slot(int'(held_total) + DEPTH - 1)];
      end
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
         error_tally++;
      end
   endtask

   always @(posedge clock) begin
      deq_result_type want;
      if (reset) begin
         head_slot  = '0;
         held_total = '0;
         owed_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_results.size() == 0) begin
               $display("%0t: result beat expected none actual %h", $time,
                        rsp_mon.popped_value);
               error_tally++;
            end else begin
               want = owed_results.pop_front();
               compare_field("popped_value", 64'(want.popped), 64'(rsp_mon.popped_value));
               compare_field("status", 64'(want.status), 64'(rsp_mon.status));
               compare_field("entry_count", 64'(want.count), 64'(rsp_mon.entry_count));
               compare_field("front_value", 64'(want.front), 64'(rsp_mon.front_value));
               compare_field("rear_value", 64'(want.rear), 64'(rsp_mon.rear_value));
               compare_field("is_empty", 64'(want.empty), 64'(rsp_mon.is_empty));
            end
         end
         if (req_mon.valid && req_mon.ready)
            owed_results.push_back(apply_operation(req_mon.kind, req_mon.data_in));
      end
      results_owed   <= owed_results.size();
      mismatch_total <= error_tally;
   end

endmodule

/* tb/tb_double_ended_queue.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// stimulus and verdict for the double-ended queue
// ----------------------------------------------------------------------------
// Drives a short directed sequence (underflow on empty, unused codes, a fill
// to full with overflow on both ends, pops from both ends, clear) and then
// several hundred random operations that drift between filling and draining
// the deque. Both sides idle at random; the result side also holds off for
// a long stretch and the operation side waits until all owed results are back.
// Checking is done by deq_checker.
// ----------------------------------------------------------------------------

module tb_double_ended_queue;
   import deq_pkg::*;

   localparam int DATA_WIDTH      = 32;
   localparam int DEPTH           = 16;
   localparam int COUNT_WIDTH     = 5;
   localparam int RANDOM_OPS      = 700;
   localparam int SINK_HOLD_CYCLES = 80;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam logic [KIND_WIDTH-1:0] KIND_SPARE_LO = 3'd5;
   localparam logic [KIND_WIDTH-1:0] KIND_SPARE_HI = 3'd7;

   logic clock = 1'b0;
   logic reset;
   bit   steady       = 1'b0;
   bit   hold_pending = 1'b0;
   int   mismatch_total;
   int   results_owed;
   int   quiet_cycles = 0;

   deq_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_bus ();
   deq_rsp_if #(.DATA_WIDTH(DATA_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) rsp_bus ();

   double_ended_queue #(
      .DATA_WIDTH (DATA_WIDTH),
      .DEPTH      (DEPTH),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   deq_checker #(
      .DATA_WIDTH (DATA_WIDTH),
      .DEPTH      (DEPTH),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .mismatch_total(mismatch_total),
      .results_owed  (results_owed)
   );

   always #5 clock = ~clock;

   initial begin
      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            rsp_bus.ready <= 1'b0;
            repeat (SINK_HOLD_CYCLES) @(posedge clock);
            hold_pending = 1'b0;
         end
         rsp_bus.ready <= steady || ($urandom_range(99) >= 36);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic offer_op(input logic [KIND_WIDTH-1:0] op, input logic [DATA_WIDTH-1:0] value);
      while (!steady && $urandom_range(99) < 36) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.kind    <= op;
      req_bus.data_in <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
   endtask

   function automatic logic [DATA_WIDTH-1:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 20) return '1;
      return DATA_WIDTH'($urandom());
   endfunction

   initial begin
      int  roll;
      bit  fill_lean;
      req_bus.valid   <= 1'b0;
      req_bus.kind    <= KIND_CLEAR;
      req_bus.data_in <= '0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // underflow at both ends, unused codes on an empty deque
      offer_op(KIND_POP_FRONT, '1);
      offer_op(KIND_POP_REAR, '1);
      for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
         offer_op(KIND_WIDTH'(k), DATA_WIDTH'($urandom()));
      // fill to full from both ends, overflow at both ends, pop both ends, clear
      offer_op(KIND_PUSH_FRONT, '1);
      offer_op(KIND_PUSH_REAR, '0);
      for (int i = 0; i < DEPTH - 2; i++)
         offer_op((i % 2) ? KIND_PUSH_FRONT : KIND_PUSH_REAR, DATA_WIDTH'($urandom()));
      offer_op(KIND_PUSH_FRONT, 32'hA5A5_A5A5);
      offer_op(KIND_PUSH_REAR, 32'h5A5A_5A5A);
      offer_op(KIND_POP_FRONT, '0);
      offer_op(KIND_POP_REAR, '0);
      offer_op(KIND_CLEAR, '1);

      fill_lean = 1'b1;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 40 == 0) fill_lean = ~fill_lean;
         if (n == 200) hold_pending = 1'b1;
         if (n == 400) wait_drained();
         steady = (n >= 450 && n < 560);
         roll = $urandom_range(99);
         if (roll < 2)
            offer_op(KIND_CLEAR, pick_value());
         else if (roll < 3)
            offer_op(KIND_WIDTH'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), pick_value());
         else if (roll < (fill_lean ? 70 : 30))
            offer_op($urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_REAR, pick_value());
         else
            offer_op($urandom_range(1) ? KIND_POP_FRONT : KIND_POP_REAR, pick_value());
      end
      steady = 1'b0;

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_total == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

/* filelist.f */
src/deq_pkg.sv
src/deq_if.sv
src/deq_cell.sv
src/double_ended_queue.sv
tb/deq_checker.sv
tb/tb_double_ended_queue.sv
